// File: hw/rtl/rk4pd_pkg.sv
// ----------------------------------------------------------------------------
// rk4pd_pkg
// Shared widths, reset values, codes and helpers of the RK4 projectile step.
// ----------------------------------------------------------------------------
`default_nettype none

package rk4pd_pkg;

  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int ProdW    = 2 * DataW;
  localparam int CntW     = $clog2(DataW);
  localparam int KW       = 17;
  localparam int HW       = 17;
  localparam int StepW    = 16;
  localparam int CfgIdxW  = 2;
  localparam int AccW     = DataW + 4;
  localparam int DivW     = AccW - 1;
  localparam int DivCntW  = $clog2(DivW);
  localparam int WideW    = ProdW + 2;

  localparam logic signed [DataW-1:0] GravityRst = -32'sd642253;
  localparam logic signed [KW-1:0]    DragRst    = -17'sd655;
  localparam logic [HW-1:0]           TimeRst    = 17'd655;
  localparam logic [StepW-1:0]        StepMax    = '1;

  localparam logic [CfgIdxW-1:0] CfgGravity = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDrag    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTime    = 2'd2;

  localparam logic signed [WideW-1:0] RoundC = WideW'(1) <<< (FracBits - 1);
  localparam logic signed [WideW-1:0] Max32W = WideW'(64'sd2147483647);
  localparam logic signed [WideW-1:0] Min32W = WideW'(-64'sd2147483648);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQRT,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_SQX,
    OP_SQY,
    OP_KV,
    OP_AX,
    OP_AY,
    OP_D0,
    OP_D1,
    OP_D2,
    OP_D3
  } op_e;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [DataW-1:0] r;
    if (v > Max32W) begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end else if (v < Min32W) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  function automatic logic [DataW-1:0] abs32(input logic signed [DataW-1:0] a);
    return a[DataW-1] ? (~a + DataW'(1)) : a;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rk4pd_if.sv
// ----------------------------------------------------------------------------
// rk4pd_if
// Valid/ready channels of the RK4 projectile step: input, result, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface rk4pd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic signed [rk4pd_pkg::DataW-1:0]   start_vx;
  logic signed [rk4pd_pkg::DataW-1:0]   start_vy;
  modport source (output valid, action, start_vx, start_vy, input ready);
  modport sink (input valid, action, start_vx, start_vy, output ready);
endinterface

interface rk4pd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [rk4pd_pkg::StepW-1:0]          step_number;
  logic signed [rk4pd_pkg::DataW-1:0]   out_vx;
  logic signed [rk4pd_pkg::DataW-1:0]   out_vy;
  logic signed [rk4pd_pkg::DataW-1:0]   out_x;
  logic signed [rk4pd_pkg::DataW-1:0]   out_y;
  logic                                 landed;
  modport source (output valid, step_number, out_vx, out_vy, out_x, out_y, landed,
                  input ready);
  modport sink (input valid, step_number, out_vx, out_vy, out_x, out_y, landed,
                output ready);
endinterface

interface rk4pd_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [rk4pd_pkg::CfgIdxW-1:0]        index;
  logic [rk4pd_pkg::DataW-1:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rk4pd_mul.sv
// ----------------------------------------------------------------------------
// rk4pd_mul
// Unsigned 32x32 shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4pd_mul (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [rk4pd_pkg::DataW-1:0]       a_i,
  input  wire logic [rk4pd_pkg::DataW-1:0]       b_i,
  output logic                                   done_o,
  output logic [rk4pd_pkg::ProdW-1:0]            prod_o
);

  logic                               busy_q;
  logic                               done_q;
  logic [rk4pd_pkg::CntW-1:0]         cnt_q;
  logic [rk4pd_pkg::DataW-1:0]        mc_q;
  logic [rk4pd_pkg::ProdW-1:0]        p_q;
  logic [rk4pd_pkg::DataW:0]          sum;

  // The multiplier sits in the low half and leaves one bit per cycle.
  assign sum = {1'b0, p_q[rk4pd_pkg::ProdW-1:rk4pd_pkg::DataW]}
             + {1'b0, (p_q[0] ? mc_q : '0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q  <= {{rk4pd_pkg::DataW{1'b0}}, b_i};
      mc_q <= a_i;
    end else if (busy_q) begin
      p_q <= {sum, p_q[rk4pd_pkg::DataW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

`default_nettype wire

// File: hw/rtl/rk4pd_sqrt.sv
// ----------------------------------------------------------------------------
// rk4pd_sqrt
// Restoring integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4pd_sqrt (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [rk4pd_pkg::ProdW-1:0]       rad_i,
  output logic                                   done_o,
  output logic [rk4pd_pkg::DataW-1:0]            root_o
);

  logic                               busy_q;
  logic                               done_q;
  logic [rk4pd_pkg::CntW-1:0]         cnt_q;
  logic [rk4pd_pkg::ProdW-1:0]        n_q;
  logic [rk4pd_pkg::DataW+1:0]        rem_q;
  logic [rk4pd_pkg::DataW-1:0]        root_q;
  logic [rk4pd_pkg::DataW+3:0]        shifted;
  logic [rk4pd_pkg::DataW+3:0]        trial;
  logic                               ge;
  logic [rk4pd_pkg::DataW+3:0]        diff;

  assign shifted = {rem_q, n_q[rk4pd_pkg::ProdW-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = (shifted >= trial);
  assign diff    = shifted - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      n_q    <= {n_q[rk4pd_pkg::ProdW-3:0], 2'b00};
      rem_q  <= ge ? diff[rk4pd_pkg::DataW+1:0] : shifted[rk4pd_pkg::DataW+1:0];
      root_q <= {root_q[rk4pd_pkg::DataW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// File: hw/rtl/rk4_projectile_drag_step.sv
// Flow: a load word, or a step word after landing, goes from ST_IDLE through ST_OUT to the
// output register. A step word runs four RK stages of nine serial multiplies and one serial
// square root, then four bit-serial divisions by six. Throughput is one word at a time, set by
// the shared multiplier; a finished word waits in the output register while the next word is
// accepted.
// Reset clears the state to zero and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// rk4_projectile_drag_step
// Fourth-order Runge-Kutta step of a 2-D projectile with quadratic drag.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4_projectile_drag_step (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  rk4pd_in_if.sink        in_i,
  rk4pd_out_if.source     out_o,
  rk4pd_cfg_if.sink       cfg_i
);

  localparam int DW = rk4pd_pkg::DataW;
  localparam int WW = rk4pd_pkg::WideW;
  localparam int AW = rk4pd_pkg::AccW;
  localparam int QW = rk4pd_pkg::DivW;

  rk4pd_pkg::state_e state_q, state_d;
  rk4pd_pkg::op_e    op_q;

  logic signed [DW-1:0] px_q, py_q, vx_q, vy_q;
  logic [rk4pd_pkg::StepW-1:0] step_q;
  logic landed_q;
  logic signed [DW-1:0] g_q;
  logic signed [rk4pd_pkg::KW-1:0] k_q;
  logic [rk4pd_pkg::HW-1:0] h_q;

  logic signed [DW-1:0] svx_q, svy_q, kv_q, ax_q, ay_q, dvx_q, speed_q;
  logic [rk4pd_pkg::ProdW-1:0] sq_q;
  logic signed [AW-1:0] acc_q [4];
  logic [1:0] stage_q, cidx_q;
  logic mgo_q, sgo_q, mneg_q, ov_q;
  logic [QW-1:0] dq_q;
  logic [2:0] drem_q;
  logic dneg_q;
  logic [rk4pd_pkg::DivCntW-1:0] dcnt_q;

  logic [rk4pd_pkg::StepW-1:0] o_step_q;
  logic signed [DW-1:0] o_vx_q, o_vy_q, o_x_q, o_y_q;
  logic o_landed_q;

  logic in_fire, cfg_fire, mul_done, sq_done, div_last, out_load, last_stage;
  logic signed [DW-1:0] opa, opb, res, res_g, dvxe, dvye, svx_n, svy_n, st_sel, new_v;
  logic [rk4pd_pkg::ProdW-1:0] prod;
  logic [DW-1:0] root;
  logic signed [WW-1:0] sp, shr;
  logic signed [AW-1:0] wres, acc_rd;
  logic [1:0] ridx;
  logic [3:0] r4;
  logic dbit;
  logic [2:0] rnext;
  logic [QW-1:0] qmag;
  logic signed [QW+1:0] qs;

  assign in_fire    = in_i.valid && in_i.ready;
  assign cfg_fire   = cfg_i.valid && cfg_i.ready;
  assign last_stage = (stage_q == 2'd3);
  assign div_last   = (state_q == rk4pd_pkg::ST_DIV) &&
                      (dcnt_q == rk4pd_pkg::DivCntW'(QW - 1));
  assign out_load   = (state_q == rk4pd_pkg::ST_OUT) && (!ov_q || out_o.ready);

  // Operand selection for the shared multiplier.
  always_comb begin
    opa = svx_q;
    opb = svx_q;
    unique case (op_q)
      rk4pd_pkg::OP_SQX: begin opa = svx_q; opb = svx_q; end
      rk4pd_pkg::OP_SQY: begin opa = svy_q; opb = svy_q; end
      rk4pd_pkg::OP_KV:  begin opa = DW'(k_q); opb = speed_q; end
      rk4pd_pkg::OP_AX:  begin opa = kv_q; opb = svx_q; end
      rk4pd_pkg::OP_AY:  begin opa = kv_q; opb = svy_q; end
      rk4pd_pkg::OP_D0:  begin opa = $signed(DW'(h_q)); opb = svx_q; end
      rk4pd_pkg::OP_D1:  begin opa = $signed(DW'(h_q)); opb = svy_q; end
      rk4pd_pkg::OP_D2:  begin opa = $signed(DW'(h_q)); opb = ax_q; end
      rk4pd_pkg::OP_D3:  begin opa = $signed(DW'(h_q)); opb = ay_q; end
      default:           begin opa = svx_q; opb = svx_q; end
    endcase
  end

  rk4pd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mgo_q),
    .a_i     (rk4pd_pkg::abs32(opa)),
    .b_i     (rk4pd_pkg::abs32(opb)),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  rk4pd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sgo_q),
    .rad_i   (sq_q),
    .done_o  (sq_done),
    .root_o  (root)
  );

  // Signed fixed-point product: round half up, floor shift, saturate.
  always_comb begin
    sp    = mneg_q ? -$signed({2'b00, prod}) : $signed({2'b00, prod});
    shr   = (sp + rk4pd_pkg::RoundC) >>> rk4pd_pkg::FracBits;
    res   = rk4pd_pkg::sat32(shr);
    res_g = rk4pd_pkg::sat32(WW'(g_q) + WW'(res));
    wres  = (stage_q == 2'd1 || stage_q == 2'd2) ? (AW'(res) <<< 1) : AW'(res);
    dvxe  = (stage_q == 2'd2) ? dvx_q : (dvx_q >>> 1);
    dvye  = (stage_q == 2'd2) ? res : (res >>> 1);
    svx_n = rk4pd_pkg::sat32(WW'(vx_q) + WW'(dvxe));
    svy_n = rk4pd_pkg::sat32(WW'(vy_q) + WW'(dvye));
  end

  // Bit-serial division of the weighted increment sum by six.
  always_comb begin
    ridx   = (state_q == rk4pd_pkg::ST_DIV) ? (cidx_q + 2'd1) : 2'd0;
    acc_rd = acc_q[ridx];
    r4     = {drem_q, dq_q[QW-1]};
    dbit   = (r4 >= 4'd6);
    rnext  = dbit ? 3'(r4 - 4'd6) : r4[2:0];
    qmag   = {dq_q[QW-2:0], dbit};
    qs     = dneg_q ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
    unique case (cidx_q)
      2'd0:    st_sel = px_q;
      2'd1:    st_sel = py_q;
      2'd2:    st_sel = vx_q;
      default: st_sel = vy_q;
    endcase
    new_v = rk4pd_pkg::sat32(WW'(st_sel) + WW'(qs));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rk4pd_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = (!in_i.action || landed_q) ? rk4pd_pkg::ST_OUT : rk4pd_pkg::ST_MUL;
        end
      end
      rk4pd_pkg::ST_MUL: begin
        if (mul_done) begin
          if (op_q == rk4pd_pkg::OP_SQY) begin
            state_d = rk4pd_pkg::ST_SQRT;
          end else if (op_q == rk4pd_pkg::OP_D3 && last_stage) begin
            state_d = rk4pd_pkg::ST_DIV;
          end
        end
      end
      rk4pd_pkg::ST_SQRT: begin
        if (sq_done) state_d = rk4pd_pkg::ST_MUL;
      end
      rk4pd_pkg::ST_DIV: begin
        if (div_last && cidx_q == 2'd3) state_d = rk4pd_pkg::ST_OUT;
      end
      rk4pd_pkg::ST_OUT: begin
        if (out_load) state_d = rk4pd_pkg::ST_IDLE;
      end
      default: state_d = rk4pd_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_i.ready        = (state_q == rk4pd_pkg::ST_IDLE);
    cfg_i.ready       = 1'b1;
    out_o.valid       = ov_q;
    out_o.step_number = o_step_q;
    out_o.out_vx      = o_vx_q;
    out_o.out_vy      = o_vy_q;
    out_o.out_x       = o_x_q;
    out_o.out_y       = o_y_q;
    out_o.landed      = o_landed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rk4pd_pkg::ST_IDLE;
      op_q     <= rk4pd_pkg::OP_SQX;
      stage_q  <= '0;
      cidx_q   <= '0;
      mgo_q    <= 1'b0;
      sgo_q    <= 1'b0;
      ov_q     <= 1'b0;
      px_q     <= '0;
      py_q     <= '0;
      vx_q     <= '0;
      vy_q     <= '0;
      step_q   <= '0;
      landed_q <= 1'b0;
      g_q      <= rk4pd_pkg::GravityRst;
      k_q      <= rk4pd_pkg::DragRst;
      h_q      <= rk4pd_pkg::TimeRst;
    end else begin
      state_q <= state_d;
      mgo_q   <= 1'b0;
      sgo_q   <= 1'b0;

      if (cfg_fire) begin
        unique case (cfg_i.index)
          rk4pd_pkg::CfgGravity: g_q <= $signed(cfg_i.data);
          rk4pd_pkg::CfgDrag:    k_q <= $signed(cfg_i.data[rk4pd_pkg::KW-1:0]);
          rk4pd_pkg::CfgTime:    h_q <= cfg_i.data[rk4pd_pkg::HW-1:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        if (!in_i.action) begin
          vx_q     <= in_i.start_vx;
          vy_q     <= in_i.start_vy;
          px_q     <= '0;
          py_q     <= '0;
          step_q   <= '0;
          landed_q <= 1'b0;
        end else if (!landed_q) begin
          op_q    <= rk4pd_pkg::OP_SQX;
          stage_q <= '0;
          mgo_q   <= 1'b1;
        end
      end

      if (state_q == rk4pd_pkg::ST_MUL && mul_done) begin
        if (op_q == rk4pd_pkg::OP_SQY) begin
          sgo_q <= 1'b1;
        end else if (op_q == rk4pd_pkg::OP_D3) begin
          if (last_stage) begin
            cidx_q <= '0;
          end else begin
            stage_q <= stage_q + 2'd1;
            op_q    <= rk4pd_pkg::OP_SQX;
            mgo_q   <= 1'b1;
          end
        end else begin
          op_q  <= rk4pd_pkg::op_e'(op_q + 4'd1);
          mgo_q <= 1'b1;
        end
      end

      if (state_q == rk4pd_pkg::ST_SQRT && sq_done) begin
        op_q  <= rk4pd_pkg::OP_KV;
        mgo_q <= 1'b1;
      end

      if (div_last) begin
        cidx_q <= cidx_q + 2'd1;
        unique case (cidx_q)
          2'd0:    px_q <= new_v;
          2'd1:    py_q <= new_v;
          2'd2:    vx_q <= new_v;
          default: begin
            vy_q     <= new_v;
            landed_q <= py_q[DW-1];
            if (step_q != rk4pd_pkg::StepMax) step_q <= step_q + 1'b1;
          end
        endcase
      end

      if (out_load) begin
        ov_q <= 1'b1;
      end else if (ov_q && out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      svx_q <= vx_q;
      svy_q <= vy_q;
      for (int i = 0; i < 4; i++) acc_q[i] <= '0;
    end

    if (mgo_q) mneg_q <= opa[DW-1] ^ opb[DW-1];

    if (state_q == rk4pd_pkg::ST_MUL && mul_done) begin
      unique case (op_q)
        rk4pd_pkg::OP_SQX: sq_q <= prod;
        rk4pd_pkg::OP_SQY: sq_q <= sq_q + prod;
        rk4pd_pkg::OP_KV:  kv_q <= res;
        rk4pd_pkg::OP_AX:  ax_q <= res;
        rk4pd_pkg::OP_AY:  ay_q <= res_g;
        rk4pd_pkg::OP_D0:  acc_q[0] <= acc_q[0] + wres;
        rk4pd_pkg::OP_D1:  acc_q[1] <= acc_q[1] + wres;
        rk4pd_pkg::OP_D2: begin
          acc_q[2] <= acc_q[2] + wres;
          dvx_q    <= res;
        end
        rk4pd_pkg::OP_D3: begin
          acc_q[3] <= acc_q[3] + wres;
          svx_q    <= svx_n;
          svy_q    <= svy_n;
          // The position sum is already complete, so its division can start.
          dq_q     <= acc_rd[AW-1] ? QW'(-acc_rd) : acc_rd[QW-1:0];
          dneg_q   <= acc_rd[AW-1];
          drem_q   <= '0;
          dcnt_q   <= '0;
        end
        default: ;
      endcase
    end

    if (state_q == rk4pd_pkg::ST_SQRT && sq_done) begin
      speed_q <= root[DW-1] ? {1'b0, {(DW-1){1'b1}}} : $signed(root);
    end

    if (state_q == rk4pd_pkg::ST_DIV) begin
      if (div_last) begin
        dq_q   <= acc_rd[AW-1] ? QW'(-acc_rd) : acc_rd[QW-1:0];
        dneg_q <= acc_rd[AW-1];
        drem_q <= '0;
        dcnt_q <= '0;
      end else begin
        dq_q   <= qmag;
        drem_q <= rnext;
        dcnt_q <= dcnt_q + 1'b1;
      end
    end

    if (out_load) begin
      o_step_q   <= step_q;
      o_vx_q     <= vx_q;
      o_vy_q     <= vy_q;
      o_x_q      <= px_q;
      o_y_q      <= py_q;
      o_landed_q <= landed_q;
    end
  end

endmodule

`default_nettype wire
